/* src/stc_pkg.sv */
// stc_pkg: shared types and constants of the space to tab compressor
// no dependencies
`default_nettype none

package stc_pkg;

    // default sizes, handed down as parameters from the top level
    localparam int MAX_STOPS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 16;
    localparam int STOP_W  = 16;
    localparam int SLOT_W  = 5;
    localparam int SCNT_W  = 5;
    localparam int RWID_W  = 8;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 1;

    localparam logic [CHAR_W-1:0]  CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0]  CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'd32;
    localparam logic [RWID_W-1:0]  WIDTH_DEF  = 8'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_STOP_COUNT   = 1'd0;
    localparam logic [CIDX_W-1:0] REG_REPEAT_WIDTH = 1'd1;

    // input word action codes
    localparam logic ACT_TEXT       = 1'b0;
    localparam logic ACT_STOP_WRITE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] char_in;
        logic [SLOT_W-1:0] stop_slot;
        logic [STOP_W-1:0] stop_column;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic [COUNT_W-1:0] out_count;
        logic               last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_LAST,
        ST_CHECK,
        ST_SCAN,
        ST_DIV,
        ST_APPLY,
        ST_EMIT_TAB,
        ST_EMIT_SP,
        ST_EMIT_CHR
    } seq_state_t;

endpackage

`default_nettype wire

/* src/stc_ram.sv */
// stc_ram: generic single write port ram with registered read
// depends on nothing
`default_nettype none

module stc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/stc_mod_unit.sv */
// stc_mod_unit: bit serial remainder of the column by the tab width
// depends on stc_pkg
`default_nettype none

module stc_mod_unit
    import stc_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [COLUMN_BITS-1:0] dividend,
    input  wire logic [RWID_W-1:0]      divisor,
    output logic                        done,
    output logic      [RWID_W-1:0]      rem
);

    localparam int SCW = $clog2(COLUMN_BITS);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [SCW-1:0]         step_reg, step_next;
    logic [COLUMN_BITS-1:0] dvd_reg, dvd_next;
    logic [RWID_W-1:0]      rem_reg, rem_next;
    logic [RWID_W:0]        trial;
    logic                   last_step;

    // one quotient bit a cycle, msb first
    always_comb begin
        trial     = {rem_reg, dvd_reg[COLUMN_BITS-1]};
        last_step = (step_reg == SCW'(COLUMN_BITS - 1));
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next  = {dvd_reg[COLUMN_BITS-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (trial >= {1'b0, divisor}) begin
                rem_next = RWID_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = RWID_W'(trial);
            end
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* src/space_to_tab_compressor.sv */
// space_to_tab_compressor: replaces runs of spaces by tab and space runs
// depends on stc_pkg, stc_ram, stc_mod_unit
//
//  channel   dir   handshake        payload
//  s_*       in    s_valid/s_ready  in_word_t: action, char_in, stop_slot, stop_column
//  m_*       out   m_valid/m_ready  out_word_t: out_char, out_count, last
//  cfg_*     in    cfg_we           cfg_index, cfg_wdata (no read-back)
//
// sequence: a space word or a stop write is taken with no result; any other word with
//   no pending spaces is accepted, then sends its result word
// with spaces pending: the last listed stop is fetched, each tab and the
//   leftover run go through check and apply, a listed stop adds a scan step per
//   entry looked at, a repeat step with the remainder not yet known (the first
//   one, after a listed stop, or after the column clips) waits on the
//   remainder unit, and each result word is then sent in turn
// the stop table read port (one registered read a cycle) sets the scan pace
// reset: synchronous, active low; the stop table is not cleared
// stalls: the output register holds a word while m_ready is low; a new word
//   is taken as soon as the last result of the previous one is loaded
`default_nettype none

module space_to_tab_compressor
    import stc_pkg::*;
#(
    parameter int MAX_STOPS   = MAX_STOPS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // text and stop table words
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,
    // result words
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    // configuration writes
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int PW = $clog2(MAX_STOPS + 1);
    localparam int WW = (COLUMN_BITS > STOP_W) ? COLUMN_BITS : STOP_W;
    localparam int SW = WW + 1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    seq_state_t state_reg, state_next;

    // settling state
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic [COUNT_W-1:0]     pend_reg, pend_next;
    logic [PW-1:0]          ptr_reg, ptr_next;
    logic [STOP_W-1:0]      last_stop_reg, last_stop_next;
    logic [COUNT_W-1:0]     d_reg, d_next;
    logic                   d_rep_reg, d_rep_next;
    logic                   mod_known_reg, mod_known_next;
    logic [COUNT_W-1:0]     tabs_reg, tabs_next;
    logic [COUNT_W-1:0]     spaces_reg, spaces_next;
    logic [CHAR_W-1:0]      char_reg, char_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    out_word_t              out_data_reg, out_data_next;

    // configuration
    logic [SCNT_W-1:0]      stop_count_reg;
    logic [RWID_W-1:0]      repeat_width_reg;

    logic                   in_accept;
    logic                   out_load;
    logic [PW-1:0]          cnt_eff;
    logic [RWID_W-1:0]      rw_eff;
    logic [PW-1:0]          ptr_inc;
    logic [WW-1:0]          col_wide;
    logic [WW-1:0]          stop_wide;
    logic                   use_repeat;
    logic                   scan_pass;
    logic                   scan_exhaust;
    logic                   tab_fits;
    logic [COUNT_W-1:0]     add_val;
    logic [SW-1:0]          col_sum;
    logic                   col_sat;
    logic [COLUMN_BITS-1:0] col_added;

    // table port
    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [STOP_W-1:0]      ram_rdata;

    // remainder unit
    logic                   mod_start;
    logic                   mod_done;
    logic [RWID_W-1:0]      mod_rem;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_load  = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // a stop count beyond the table acts as the table size, width zero as default
    assign cnt_eff = (stop_count_reg > MAX_STOPS) ? PW'(MAX_STOPS) : PW'(stop_count_reg);
    assign rw_eff  = (repeat_width_reg == '0) ? WIDTH_DEF : repeat_width_reg;

    assign ptr_inc    = ptr_reg + 1'b1;
    assign col_wide   = WW'(column_reg);
    assign stop_wide  = WW'(ram_rdata);

    // listed stops only apply while the column sits before the last one in use
    assign use_repeat   = (cnt_eff == '0) || (ptr_reg >= cnt_eff)
                       || (col_wide >= WW'(last_stop_reg));
    assign scan_pass    = (stop_wide <= col_wide);
    assign scan_exhaust = scan_pass && (ptr_inc >= cnt_eff);

    // saturating column add, shared by the tab and leftover cases
    assign tab_fits  = (pend_reg >= d_reg);
    assign add_val   = tab_fits ? d_reg : pend_reg;
    assign col_sum   = SW'(column_reg) + SW'(add_val);
    assign col_sat   = (col_sum > SW'(COL_MAX));
    assign col_added = col_sat ? COL_MAX : COLUMN_BITS'(col_sum);

    // table writes come straight from the input word
    assign ram_we = in_accept && (s_data.action == ACT_STOP_WRITE)
                 && (s_data.stop_slot < MAX_STOPS);

    always_comb begin
        unique case (state_reg)
            ST_IDLE:  ram_raddr = AW'(cnt_eff - 1'b1);
            ST_SCAN:  ram_raddr = AW'(ptr_inc);
            default:  ram_raddr = AW'(ptr_reg);
        endcase
    end

    stc_ram #(
        .WIDTH (STOP_W),
        .DEPTH (MAX_STOPS)
    ) u_stop_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(s_data.stop_slot)),
        .wdata (s_data.stop_column),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stc_mod_unit #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_mod_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (column_reg),
        .divisor  (rw_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_data.action == ACT_TEXT)
                    && (s_data.char_in != CHAR_SPACE)) begin
                    state_next = (pend_reg == '0) ? ST_EMIT_CHR : ST_LOAD_LAST;
                end
            end
            ST_LOAD_LAST: state_next = ST_CHECK;
            ST_CHECK: begin
                if (!use_repeat) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = mod_known_reg ? ST_APPLY : ST_DIV;
                end
            end
            ST_SCAN: begin
                if (!scan_pass) begin
                    state_next = ST_APPLY;
                end else if (scan_exhaust) begin
                    state_next = mod_known_reg ? ST_APPLY : ST_DIV;
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (tab_fits && (pend_reg != d_reg)) begin
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_EMIT_TAB;
                end
            end
            ST_EMIT_TAB: begin
                if ((tabs_reg == '0) || out_load) begin
                    state_next = ST_EMIT_SP;
                end
            end
            ST_EMIT_SP: begin
                if ((spaces_reg == '0) || out_load) begin
                    state_next = ST_EMIT_CHR;
                end
            end
            ST_EMIT_CHR: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        column_next    = column_reg;
        pend_next      = pend_reg;
        ptr_next       = ptr_reg;
        last_stop_next = last_stop_reg;
        d_next         = d_reg;
        d_rep_next     = d_rep_reg;
        mod_known_next = mod_known_reg;
        tabs_next      = tabs_reg;
        spaces_next    = spaces_reg;
        char_next      = char_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        mod_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_data.action == ACT_TEXT)) begin
                    if (s_data.char_in == CHAR_SPACE) begin
                        if (pend_reg != COUNT_MAX) begin
                            pend_next = pend_reg + 1'b1;
                        end
                    end else begin
                        char_next      = s_data.char_in;
                        tabs_next      = '0;
                        spaces_next    = '0;
                        mod_known_next = 1'b0;
                    end
                end
            end
            ST_LOAD_LAST: last_stop_next = ram_rdata;
            ST_CHECK: begin
                if (use_repeat) begin
                    if (mod_known_reg) begin
                        d_next     = COUNT_W'(rw_eff);
                        d_rep_next = 1'b1;
                    end else begin
                        mod_start = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (!scan_pass) begin
                    d_next     = COUNT_W'(stop_wide - col_wide);
                    d_rep_next = 1'b0;
                    ptr_next   = ptr_inc;
                end else begin
                    ptr_next = ptr_inc;
                    if (scan_exhaust) begin
                        if (mod_known_reg) begin
                            d_next     = COUNT_W'(rw_eff);
                            d_rep_next = 1'b1;
                        end else begin
                            mod_start = 1'b1;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (mod_done) begin
                    d_next     = COUNT_W'(rw_eff) - COUNT_W'(mod_rem);
                    d_rep_next = 1'b1;
                end
            end
            ST_APPLY: begin
                column_next = col_added;
                if (tab_fits) begin
                    tabs_next      = tabs_reg + 1'b1;
                    pend_next      = pend_reg - d_reg;
                    // a repeat stop lands on a multiple of the width unless clipped
                    mod_known_next = d_rep_reg && !col_sat;
                end else begin
                    spaces_next = pend_reg;
                    pend_next   = '0;
                end
            end
            ST_EMIT_TAB: begin
                if ((tabs_reg != '0) && out_load) begin
                    out_valid_next          = 1'b1;
                    out_data_next.out_char  = CHAR_TAB;
                    out_data_next.out_count = tabs_reg;
                    out_data_next.last      = 1'b0;
                end
            end
            ST_EMIT_SP: begin
                if ((spaces_reg != '0) && out_load) begin
                    out_valid_next          = 1'b1;
                    out_data_next.out_char  = CHAR_SPACE;
                    out_data_next.out_count = spaces_reg;
                    out_data_next.last      = 1'b0;
                end
            end
            ST_EMIT_CHR: begin
                if (out_load) begin
                    out_valid_next          = 1'b1;
                    out_data_next.out_char  = char_reg;
                    out_data_next.out_count = COUNT_W'(1);
                    out_data_next.last      = 1'b1;
                    if (char_reg == CHAR_NL) begin
                        column_next = '0;
                        ptr_next    = '0;
                    end else if (column_reg != COL_MAX) begin
                        column_next = column_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            column_reg       <= '0;
            pend_reg         <= '0;
            ptr_reg          <= '0;
            mod_known_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            stop_count_reg   <= '0;
            repeat_width_reg <= WIDTH_DEF;
        end else begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            pend_reg      <= pend_next;
            ptr_reg       <= ptr_next;
            mod_known_reg <= mod_known_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_STOP_COUNT:   stop_count_reg   <= SCNT_W'(cfg_wdata);
                    REG_REPEAT_WIDTH: repeat_width_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        last_stop_reg <= last_stop_next;
        d_reg         <= d_next;
        d_rep_reg     <= d_rep_next;
        tabs_reg      <= tabs_next;
        spaces_reg    <= spaces_next;
        char_reg      <= char_next;
        out_data_reg  <= out_data_next;
    end

    // settling must consume every pending space before the byte goes out
    a_pend_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_CHR) |-> (pend_reg == '0))
        else $error("pending spaces left at byte emit");

    // remainder results only arrive while the sequencer waits for them
    a_mod_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == ST_DIV))
        else $error("remainder done outside divide state");

    // settling only moves the column forward
    a_col_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |=> (column_reg >= $past(column_reg)))
        else $error("column moved backward while settling");

    // every result word repeats its character at least once
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_count != '0))
        else $error("result word with zero count");

endmodule

`default_nettype wire

/* sim/tb.sv */
// tb: self-checking testbench for space_to_tab_compressor
// depends on stc_pkg and the space_to_tab_compressor rtl; needs no files or arguments
`timescale 1ns / 1ps

module tb;
    import stc_pkg::*;

    localparam int          N_STOPS = MAX_STOPS_DEF;
    localparam int unsigned COL_TOP = (1 << COLUMN_BITS_DEF) - 1;
    localparam out_word_t   NIL     = '0;

    typedef enum int {STOPS_RISING, STOPS_SHUFFLED, STOPS_WIDE} stop_pattern_t;

    // one word of the directed script; typed rows carry their runs, others use the model
    typedef struct packed {
        in_word_t             word;
        logic                 typed;
        logic [1:0]           n_res;
        out_word_t [0:2]      res;
    } stim_row_t;

    logic      aclk;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_data;
    logic                 cfg_we    = 1'b0;
    logic [CIDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    space_to_tab_compressor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // run words still owed by the block, oldest first
    out_word_t runs_due [$];
    stim_row_t script [$];
    int        mismatches = 0;
    // when set, both sides run back to back with no idle cycles
    bit        quiet = 1'b0;

    // mirror of the block state and its two registers
    int unsigned col_q    = 0;
    int unsigned pend_q   = 0;
    int unsigned ptr_q    = 0;
    int unsigned stops_q [N_STOPS];
    int unsigned scount_q = 0;
    int unsigned rwidth_q = WIDTH_DEF;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: consumes one accepted word, returns the runs it causes
    // ------------------------------------------------------------------
    function automatic int entab_word(input in_word_t w, output out_word_t [0:2] res);
        int unsigned lim, rw, d, tabs, spc;
        int          k;
        res  = '0;
        tabs = 0;
        spc  = 0;
        k    = 0;
        // table write: slots past the table are dropped
        if (w.action == ACT_STOP_WRITE) begin
            if (w.stop_slot < N_STOPS) stops_q[w.stop_slot] = w.stop_column;
            return 0;
        end
        // a space only grows the pending run, which saturates
        if (w.char_in == CHAR_SPACE) begin
            if (pend_q < COUNT_MAX) pend_q++;
            return 0;
        end
        // oversized stop count clips to the table size, zero width means default
        lim = (scount_q > N_STOPS) ? N_STOPS : scount_q;
        rw  = (rwidth_q == 0) ? WIDTH_DEF : rwidth_q;
        while (pend_q != 0) begin
            // listed stops apply only while the column is before the last one in use
            if (lim == 0 || ptr_q >= lim || col_q >= stops_q[lim-1]) begin
                d = rw - (col_q % rw);
            end else begin
                // skip entries at or behind the column (handles unsorted tables)
                while (ptr_q < lim && stops_q[ptr_q] <= col_q) ptr_q++;
                if (ptr_q >= lim) begin
                    d = rw - (col_q % rw);
                end else begin
                    d = stops_q[ptr_q] - col_q;
                    ptr_q++;
                end
            end
            if (pend_q >= d) begin
                tabs++;
                col_q  = (col_q + d > COL_TOP) ? COL_TOP : col_q + d;
                pend_q = pend_q - d;
            end else begin
                col_q  = (col_q + pend_q > COL_TOP) ? COL_TOP : col_q + pend_q;
                spc    = pend_q;
                pend_q = 0;
            end
        end
        // zero-length runs are left out
        if (tabs != 0) begin
            res[k] = '{CHAR_TAB, COUNT_W'(tabs), 1'b0};
            k++;
        end
        if (spc != 0) begin
            res[k] = '{CHAR_SPACE, COUNT_W'(spc), 1'b0};
            k++;
        end
        res[k] = '{w.char_in, COUNT_W'(1), 1'b1};
        k++;
        // newline rewinds, anything else advances one column (saturating)
        if (w.char_in == CHAR_NL) begin
            col_q = 0;
            ptr_q = 0;
        end else if (col_q < COL_TOP) begin
            col_q++;
        end
        return k;
    endfunction

    // ------------------------------------------------------------------
    // word builders; unused fields carry random noise
    // ------------------------------------------------------------------
    function automatic in_word_t text_of(input logic [CHAR_W-1:0] c);
        text_of.action      = ACT_TEXT;
        text_of.char_in     = c;
        text_of.stop_slot   = SLOT_W'($urandom);
        text_of.stop_column = STOP_W'($urandom);
    endfunction

    function automatic in_word_t stop_write(input int slot, input int unsigned col);
        stop_write.action      = ACT_STOP_WRITE;
        stop_write.char_in     = CHAR_W'($urandom);
        stop_write.stop_slot   = SLOT_W'(slot);
        stop_write.stop_column = STOP_W'(col);
    endfunction

    function automatic out_word_t run_of(input logic [CHAR_W-1:0] c, input int n,
                                         input logic l);
        run_of = '{c, COUNT_W'(n), l};
    endfunction

    function automatic stim_row_t row(input in_word_t w, input logic typed, input int n,
                                      input out_word_t a, input out_word_t b);
        row = '{w, typed, 2'(n), {a, b, NIL}};
    endfunction

    function automatic stim_row_t plain(input in_word_t w);
        plain      = '0;
        plain.word = w;
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // ------------------------------------------------------------------
    // input side: idle, offer the word until taken, then book its runs
    // ------------------------------------------------------------------
    task automatic send(input stim_row_t r);
        out_word_t [0:2] got;
        int              n;
        int              gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r.word;
        do @(posedge aclk); while (!s_ready);
        // word taken at this edge
        n = entab_word(r.word, got);
        if (r.typed) n = r.n_res;
        for (int k = 0; k < n; k++) runs_due.push_back(r.typed ? r.res[k] : got[k]);
    endtask

    // let every owed run come back, then give a stop write time to land
    task automatic drain(input int settle);
        s_valid <= 1'b0;
        while (runs_due.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // registers change only with the block idle
    task automatic new_phase(input int sc, input int rw);
        drain(40);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STOP_COUNT;
        cfg_wdata <= {3'($urandom), SCNT_W'(sc)};   // upper bits are don't-care
        @(posedge aclk);
        cfg_index <= REG_REPEAT_WIDTH;
        cfg_wdata <= RWID_W'(rw);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        scount_q = sc & 31;
        rwidth_q = rw & 255;
    endtask

    // write all table entries so no later read hits an unwritten one
    task automatic load_stops(input stop_pattern_t pat);
        int unsigned c;
        c = 0;
        for (int i = 0; i < N_STOPS; i++) begin
            case (pat)
                STOPS_RISING:   c = c + $urandom_range(1, 9);
                STOPS_SHUFFLED: c = $urandom_range(0, 80);
                default:        c = (i == N_STOPS - 1) ? 32'hFFFF : c + $urandom_range(1, 3000);
            endcase
            send(plain(stop_write(i, c)));
        end
    endtask

    // mostly lines of space runs and words, plus stray bytes and table writes
    task automatic run_text(input int n);
        int sent;
        int pick;
        int run_len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 15) == 0) quiet = !quiet;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send(plain(stop_write($urandom_range(0, 31),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 90))));
                sent++;
            end else if (pick < 20) begin
                send(plain(text_of(CHAR_W'($urandom))));
                sent++;
            end else begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70)
                                                      : $urandom_range(0, 12);
                repeat (run_len) send(plain(text_of(CHAR_SPACE)));
                send(plain(text_of(($urandom_range(0, 5) == 0) ? CHAR_NL
                                       : CHAR_W'($urandom_range(33, 126)))));
                sent += run_len + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random stall before each word
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic flag(input string what, input int want, input int seen);
        mismatches++;
        $display("%0t ns: %s expected %0d, got %0d", $time, what, want, seen);
    endtask

    // checker: every word taken from m_ against the oldest owed run
    out_word_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (runs_due.size() == 0) begin
                flag("unowed word, out_char", -1, m_data.out_char);
            end else begin
                want = runs_due.pop_front();
                if (m_data.out_char !== want.out_char)
                    flag("out_char", want.out_char, m_data.out_char);
                if (m_data.out_count !== want.out_count)
                    flag("out_count", want.out_count, m_data.out_count);
                if (m_data.last !== want.last)
                    flag("last", want.last, m_data.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        foreach (stops_q[i]) stops_q[i] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed script at reset settings: no listed stops, width 8
        script.push_back(row(text_of(8'h41), 1'b1, 1, run_of(8'h41, 1, 1'b1), NIL));
        repeat (3) script.push_back(row(text_of(CHAR_SPACE), 1'b1, 0, NIL, NIL));
        // three spaces at column 1 fall short of the stop at 8
        script.push_back(row(text_of(8'h42), 1'b1, 2, run_of(CHAR_SPACE, 3, 1'b0),
                             run_of(8'h42, 1, 1'b1)));
        repeat (3) script.push_back(row(text_of(CHAR_SPACE), 1'b0, 0, NIL, NIL));
        // three spaces at column 5 reach the stop exactly: one tab
        script.push_back(row(text_of(8'h00), 1'b1, 2, run_of(CHAR_TAB, 1, 1'b0),
                             run_of(8'h00, 1, 1'b1)));
        script.push_back(row(text_of(8'hFF), 1'b1, 1, run_of(8'hFF, 1, 1'b1), NIL));
        script.push_back(row(text_of(CHAR_NL), 1'b1, 1, run_of(CHAR_NL, 1, 1'b1), NIL));
        // a space before a newline still comes out
        script.push_back(row(text_of(CHAR_SPACE), 1'b1, 0, NIL, NIL));
        script.push_back(row(text_of(CHAR_NL), 1'b1, 2, run_of(CHAR_SPACE, 1, 1'b0),
                             run_of(CHAR_NL, 1, 1'b1)));
        // table writes past the last slot are dropped
        script.push_back(row(stop_write(31, 32'hFFFF), 1'b1, 0, NIL, NIL));
        script.push_back(row(stop_write(N_STOPS, 0), 1'b1, 0, NIL, NIL));
        script.push_back(row(stop_write(0, 3), 1'b0, 0, NIL, NIL));
        repeat (8) script.push_back(row(text_of(CHAR_SPACE), 1'b0, 0, NIL, NIL));
        script.push_back(row(text_of(8'h78), 1'b0, 0, NIL, NIL));
        foreach (script[i]) send(script[i]);

        // random phases over a spread of register settings
        load_stops(STOPS_RISING);
        new_phase(N_STOPS, 1);
        run_text(60);

        // stop count past the table size, widest spacing, unsorted stops
        load_stops(STOPS_SHUFFLED);
        new_phase(31, 255);
        run_text(60);

        // zero width behaves as the default
        new_phase(0, 0);
        run_text(60);

        load_stops(STOPS_RISING);
        new_phase($urandom_range(1, N_STOPS - 1), $urandom_range(1, 254));
        run_text(60);

        // far-apart stops up to the top column
        load_stops(STOPS_WIDE);
        new_phase(3, 5);
        run_text(60);

        new_phase($urandom_range(0, 31), $urandom_range(0, 255));
        run_text(60);
        // trailing spaces stay held and owe nothing
        repeat (5) send(plain(text_of(CHAR_SPACE)));

        drain(60);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
